/* rtl/core/sorted_priority_queue_unit_assert.svh */
// Assertion macros shared by the sorted priority queue RTL.
`ifndef SORTED_PRIORITY_QUEUE_UNIT_ASSERT_SVH
`define SORTED_PRIORITY_QUEUE_UNIT_ASSERT_SVH

`ifndef SYNTHESIS

// The property must hold at every clock edge outside reset.
`define SPQ_ASSERT_ALWAYS(lbl, clk, rst_n, cond) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (cond)) \
        else $error("sorted priority queue: invariant violated");

// When the antecedent holds, the consequent holds on the same edge.
`define SPQ_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("sorted priority queue: implication violated");

// When the antecedent holds, the consequent holds on the next edge.
`define SPQ_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("sorted priority queue: next-cycle check violated");

`else

`define SPQ_ASSERT_ALWAYS(lbl, clk, rst_n, cond)
`define SPQ_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define SPQ_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

/* rtl/core/spq_pkg.sv */
// Package with types, codes and widths of the sorted priority queue.
`timescale 1ns / 1ps

package spq_pkg;

    localparam int FUNC_W    = 2;
    localparam int PRIO_W    = 16;
    localparam int PAYLOAD_W = 32;
    localparam int STATUS_W  = 2;
    localparam int COUNT_W   = 5;

    localparam int DEF_CAPACITY  = 16;
    localparam int DEF_DATA_BITS = 32;

    typedef enum logic [FUNC_W-1:0] {
        FN_INSERT = 2'd0,
        FN_POP    = 2'd1,
        FN_CLEAR  = 2'd2
    } t_func;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 2'd0,
        ST_POP_EMPTY = 2'd1,
        ST_INS_FULL  = 2'd2,
        ST_CLR_EMPTY = 2'd3
    } t_status;

    // Per-slot update controls driven by the queue store.
    typedef struct packed {
        logic ins;
        logic pop;
    } t_slot_ctl;

    // Operation issued from the input stage to the queue store.
    typedef struct packed {
        logic  go;
        t_func func;
    } t_op;

endpackage

/* rtl/core/spq_slot.sv */
// One queue slot: holds a pair, compares against the new priority, shifts.
`timescale 1ns / 1ps

module spq_slot #(
    parameter int DATA_BITS = spq_pkg::DEF_DATA_BITS
) (
    input  logic                              i_clk,
    input  spq_pkg::t_slot_ctl                i_ctl,
    input  logic                              i_below_fill,
    input  logic                              i_at_fill,
    input  logic                              i_lt_prev,
    input  logic signed [spq_pkg::PRIO_W-1:0] i_new_prio,
    input  logic [DATA_BITS-1:0]              i_new_data,
    input  logic signed [spq_pkg::PRIO_W-1:0] i_prev_prio,
    input  logic [DATA_BITS-1:0]              i_prev_data,
    input  logic signed [spq_pkg::PRIO_W-1:0] i_next_prio,
    input  logic [DATA_BITS-1:0]              i_next_data,
    output logic                              o_lt,
    output logic signed [spq_pkg::PRIO_W-1:0] o_prio,
    output logic [DATA_BITS-1:0]              o_data,
    output logic signed [spq_pkg::PRIO_W-1:0] o_next_prio,
    output logic [DATA_BITS-1:0]              o_next_data
);

    logic signed [spq_pkg::PRIO_W-1:0] r_prio;
    logic [DATA_BITS-1:0]              r_data;
    logic signed [spq_pkg::PRIO_W-1:0] n_prio;
    logic [DATA_BITS-1:0]              n_data;

    // A held entry with lower priority than the new one moves back by one.
    assign o_lt = i_below_fill && (r_prio < i_new_prio);

    always_comb begin
        n_prio = r_prio;
        n_data = r_data;
        if (i_ctl.ins) begin
            if (i_lt_prev) begin
                n_prio = i_prev_prio;
                n_data = i_prev_data;
            end else if (o_lt || i_at_fill) begin
                n_prio = i_new_prio;
                n_data = i_new_data;
            end
        end else if (i_ctl.pop) begin
            n_prio = i_next_prio;
            n_data = i_next_data;
        end
    end

    always_ff @(posedge i_clk) begin
        r_prio <= n_prio;
        r_data <= n_data;
    end

    assign o_prio      = r_prio;
    assign o_data      = r_data;
    assign o_next_prio = n_prio;
    assign o_next_data = n_data;

endmodule

/* rtl/core/spq_store.sv */
// Queue store: the row of slots, the fill count and the operation status.
`timescale 1ns / 1ps

module spq_store #(
    parameter int CAPACITY  = spq_pkg::DEF_CAPACITY,
    parameter int DATA_BITS = spq_pkg::DEF_DATA_BITS,
    localparam int CNT_W    = $clog2(CAPACITY + 1)
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  spq_pkg::t_op                      i_op,
    input  logic signed [spq_pkg::PRIO_W-1:0] i_prio,
    input  logic [DATA_BITS-1:0]              i_data,
    output spq_pkg::t_status                  o_status,
    output logic [CNT_W-1:0]                  o_fill,
    output logic [CNT_W-1:0]                  o_next_fill,
    output logic signed [spq_pkg::PRIO_W-1:0] o_head_prio,
    output logic [DATA_BITS-1:0]              o_head_data
);

    logic [CNT_W-1:0]   r_fill;
    logic [CNT_W-1:0]   n_fill;
    spq_pkg::t_slot_ctl w_ctl;

    logic                              w_lt        [CAPACITY];
    logic signed [spq_pkg::PRIO_W-1:0] w_prio      [CAPACITY];
    logic [DATA_BITS-1:0]              w_data      [CAPACITY];
    logic signed [spq_pkg::PRIO_W-1:0] w_next_prio [CAPACITY];
    logic [DATA_BITS-1:0]              w_next_data [CAPACITY];

    always_comb begin
        o_status  = spq_pkg::ST_OK;
        n_fill    = r_fill;
        w_ctl.ins = 1'b0;
        w_ctl.pop = 1'b0;
        case (i_op.func)
            spq_pkg::FN_INSERT: begin
                if (r_fill == CNT_W'(CAPACITY)) begin
                    o_status = spq_pkg::ST_INS_FULL;
                end else begin
                    w_ctl.ins = i_op.go;
                    n_fill    = r_fill + CNT_W'(1);
                end
            end
            spq_pkg::FN_POP: begin
                if (r_fill == '0) begin
                    o_status = spq_pkg::ST_POP_EMPTY;
                end else begin
                    w_ctl.pop = i_op.go;
                    n_fill    = r_fill - CNT_W'(1);
                end
            end
            spq_pkg::FN_CLEAR: begin
                if (r_fill == '0) begin
                    o_status = spq_pkg::ST_CLR_EMPTY;
                end else begin
                    n_fill = '0;
                end
            end
            default: begin
                n_fill = r_fill;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= '0;
        end else if (i_op.go) begin
            r_fill <= n_fill;
        end
    end

    for (genvar gi = 0; gi < CAPACITY; gi++) begin : g_slot
        logic                              w_lt_prev;
        logic signed [spq_pkg::PRIO_W-1:0] w_prev_prio;
        logic [DATA_BITS-1:0]              w_prev_data;
        logic signed [spq_pkg::PRIO_W-1:0] w_nb_prio;
        logic [DATA_BITS-1:0]              w_nb_data;

        if (gi == 0) begin : g_first
            assign w_lt_prev   = 1'b0;
            assign w_prev_prio = i_prio;
            assign w_prev_data = i_data;
        end else begin : g_mid
            assign w_lt_prev   = w_lt[gi-1];
            assign w_prev_prio = w_prio[gi-1];
            assign w_prev_data = w_data[gi-1];
        end

        if (gi == CAPACITY - 1) begin : g_last
            assign w_nb_prio = w_prio[gi];
            assign w_nb_data = w_data[gi];
        end else begin : g_inner
            assign w_nb_prio = w_prio[gi+1];
            assign w_nb_data = w_data[gi+1];
        end

        spq_slot #(
            .DATA_BITS(DATA_BITS)
        ) u_slot (
            .i_clk       (i_clk),
            .i_ctl       (w_ctl),
            .i_below_fill(CNT_W'(gi) < r_fill),
            .i_at_fill   (CNT_W'(gi) == r_fill),
            .i_lt_prev   (w_lt_prev),
            .i_new_prio  (i_prio),
            .i_new_data  (i_data),
            .i_prev_prio (w_prev_prio),
            .i_prev_data (w_prev_data),
            .i_next_prio (w_nb_prio),
            .i_next_data (w_nb_data),
            .o_lt        (w_lt[gi]),
            .o_prio      (w_prio[gi]),
            .o_data      (w_data[gi]),
            .o_next_prio (w_next_prio[gi]),
            .o_next_data (w_next_data[gi])
        );
    end

    assign o_fill      = r_fill;
    assign o_next_fill = n_fill;
    assign o_head_prio = w_next_prio[0];
    assign o_head_data = w_next_data[0];

endmodule

/* rtl/core/sorted_priority_queue_unit.sv */
// Top level of the sorted priority queue: stream ports, stage registers, checks.
//
//   Channel   Dir  tdata (low bit up)                                   tuser
//   s (in)    in   prio[15:0], payload[47:16]                           func[1:0]
//   m (out)   out  has_head[0], head_prio[16:1], head_data[48:17],      status[1:0]
//                  entry_count[53:49], zero pad[55:54]
//
// Per cycle, one transfer enters the input register unless the output stalls.
// The single update stage compares the new priority against every slot in parallel
// and shifts the row in the same cycle, so it sets the one-item-per-cycle figure.
// Reset (i_rst_n low at a clock edge) empties the queue and both stage registers.
// A stall on the output holds the result register and, once the input register
// is full, deasserts o_s_tready; no transfer is lost or repeated.
`timescale 1ns / 1ps
`include "sorted_priority_queue_unit_assert.svh"

module sorted_priority_queue_unit #(
    parameter int CAPACITY  = spq_pkg::DEF_CAPACITY,
    parameter int DATA_BITS = spq_pkg::DEF_DATA_BITS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [47:0] i_s_tdata,   // prio[15:0], payload[47:16]
    input  logic [1:0]  i_s_tuser,   // func[1:0]
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [55:0] o_m_tdata,   // has_head, head_prio, head_data, entry_count
    output logic [1:0]  o_m_tuser    // status[1:0]
);

    localparam int CNT_W = $clog2(CAPACITY + 1);

    // Input stage register.
    logic                                 r_in_valid;
    spq_pkg::t_func                       r_in_func;
    logic signed [spq_pkg::PRIO_W-1:0]    r_in_prio;
    logic signed [spq_pkg::PAYLOAD_W-1:0] r_in_payload;

    // Result register.
    logic                                 r_out_valid;
    spq_pkg::t_status                     r_out_status;
    logic                                 r_out_has_head;
    logic signed [spq_pkg::PRIO_W-1:0]    r_out_prio;
    logic signed [spq_pkg::PAYLOAD_W-1:0] r_out_data;
    logic [spq_pkg::COUNT_W-1:0]          r_out_count;

    logic                              w_adv;
    spq_pkg::t_op                      w_op;
    spq_pkg::t_status                  w_status;
    logic [CNT_W-1:0]                  w_fill;
    logic [CNT_W-1:0]                  w_next_fill;
    logic signed [spq_pkg::PRIO_W-1:0] w_head_prio;
    logic [DATA_BITS-1:0]              w_head_data;
    logic [DATA_BITS-1:0]              w_in_data;
    logic                              w_has_head;

    // The update stage moves whenever the result register is free or draining.
    assign w_adv      = !r_out_valid || i_m_tready;
    assign o_s_tready = !r_in_valid || w_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_tready) begin
            r_in_valid <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_tready && i_s_tvalid) begin
            r_in_func    <= spq_pkg::t_func'(i_s_tuser);
            r_in_prio    <= i_s_tdata[15:0];
            r_in_payload <= i_s_tdata[47:16];
        end
    end

    // The payload is kept sign-extended or truncated to the stored data width.
    assign w_in_data = DATA_BITS'(r_in_payload);
    assign w_op.go   = r_in_valid && w_adv;
    assign w_op.func = r_in_func;

    spq_store #(
        .CAPACITY (CAPACITY),
        .DATA_BITS(DATA_BITS)
    ) u_store (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_op       (w_op),
        .i_prio     (r_in_prio),
        .i_data     (w_in_data),
        .o_status   (w_status),
        .o_fill     (w_fill),
        .o_next_fill(w_next_fill),
        .o_head_prio(w_head_prio),
        .o_head_data(w_head_data)
    );

    assign w_has_head = (w_next_fill != '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= r_in_valid;
        end
    end

    // The head fields read as zero whenever the queue is empty after the operation.
    always_ff @(posedge i_clk) begin
        if (w_op.go) begin
            r_out_status   <= w_status;
            r_out_has_head <= w_has_head;
            r_out_prio     <= w_has_head ? w_head_prio : '0;
            r_out_data     <= w_has_head ? spq_pkg::PAYLOAD_W'(signed'(w_head_data)) : '0;
            r_out_count    <= spq_pkg::COUNT_W'(w_next_fill);
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tuser  = r_out_status;
    assign o_m_tdata  = {2'b00, r_out_count, r_out_data, r_out_prio, r_out_has_head};

    // The fill count never passes the queue depth.
    `SPQ_ASSERT_ALWAYS(a_fill_bound, i_clk, i_rst_n, w_fill <= CNT_W'(CAPACITY))

    // A rejected insert leaves the count untouched.
    `SPQ_ASSERT_NEXT(a_full_keeps, i_clk, i_rst_n,
        w_op.go && w_status == spq_pkg::ST_INS_FULL, w_fill == CNT_W'(CAPACITY))

    // Without an operation issued the count holds.
    `SPQ_ASSERT_NEXT(a_idle_holds, i_clk, i_rst_n, !w_op.go, $stable(w_fill))

    // Any status other than ok reports a count that did not move.
    `SPQ_ASSERT_IMP(a_err_no_change, i_clk, i_rst_n,
        w_status != spq_pkg::ST_OK, w_next_fill == w_fill)

endmodule
